[rtl/mkwd_pkg.sv]
// Shared types and constants for the keystream word decryptor.
// No dependencies; used by mkwd_gen and minstd_keystream_word_decrypt.
package mkwd_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned CNT_W    = 30;
    localparam int unsigned VB_W     = 3;
    localparam int unsigned B_W      = 17;
    localparam int unsigned CFG_IDX_W = 1;

    // Schrage-form generator constants
    localparam logic [WORD_W-1:0] KS_MUL = 32'h5E47_89C9;
    localparam logic [WORD_W-1:0] KS_Q   = 32'h0000_ADC8;
    localparam logic [WORD_W-1:0] KS_A   = 32'h0000_BC8F;
    localparam logic [WORD_W-1:0] KS_R   = 32'h0000_0D47;
    localparam logic [WORD_W-1:0] KS_FIX = 32'h7FFF_FFFF;
    localparam int unsigned       KS_SHIFT = 46;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BUFFER_OFFSET = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BUFFER_LENGTH = 1'b1;

    // Sub-steps of one generator step on the shared multiplier
    typedef enum logic [2:0] {
        PH_MULB,
        PH_T,
        PH_C,
        PH_R,
        PH_FIX
    } t_phase;

    typedef struct packed {
        logic   load;
        logic   run;
        t_phase phase;
    } t_gen_ctrl;

endpackage

[rtl/mkwd_gen.sv]
// Keystream generator datapath: one shared 32x32 multiplier stepped through
// the Schrage sub-steps by the sequencer in the top level. Uses mkwd_pkg.
module mkwd_gen (
    input  logic                          i_clk,
    input  mkwd_pkg::t_gen_ctrl           i_ctrl,
    input  logic [mkwd_pkg::WORD_W-1:0]   i_seed,
    output logic [mkwd_pkg::WORD_W-1:0]   o_ks
);

    logic [mkwd_pkg::WORD_W-1:0]   r_key;
    logic [mkwd_pkg::B_W-1:0]      r_b;
    logic [mkwd_pkg::WORD_W-1:0]   r_t;
    logic [mkwd_pkg::WORD_W-1:0]   r_c;
    logic [mkwd_pkg::WORD_W-1:0]   r_ks;

    logic [mkwd_pkg::WORD_W-1:0]   mul_a;
    logic [mkwd_pkg::WORD_W-1:0]   mul_b;
    logic [2*mkwd_pkg::WORD_W-1:0] prod;
    logic [mkwd_pkg::WORD_W-1:0]   key_fixed;
    logic [mkwd_pkg::WORD_W-1:0]   b_ext;

    assign b_ext = {{(mkwd_pkg::WORD_W-mkwd_pkg::B_W){1'b0}}, r_b};

    // operand select for the shared multiplier
    always_comb begin
        mul_a = r_key;
        mul_b = mkwd_pkg::KS_MUL;
        case (i_ctrl.phase)
            mkwd_pkg::PH_MULB: begin
                mul_a = r_key;
                mul_b = mkwd_pkg::KS_MUL;
            end
            mkwd_pkg::PH_T: begin
                mul_a = b_ext;
                mul_b = mkwd_pkg::KS_Q;
            end
            mkwd_pkg::PH_C: begin
                mul_a = b_ext;
                mul_b = mkwd_pkg::KS_R;
            end
            mkwd_pkg::PH_R: begin
                mul_a = r_t;
                mul_b = mkwd_pkg::KS_A;
            end
            default: begin
                mul_a = r_key;
                mul_b = mkwd_pkg::KS_MUL;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // zero or negative result wraps back into range
    assign key_fixed = ((r_key == '0) || r_key[mkwd_pkg::WORD_W-1])
                     ? r_key + mkwd_pkg::KS_FIX : r_key;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_key <= i_seed;
        end else if (i_ctrl.run) begin
            case (i_ctrl.phase)
                mkwd_pkg::PH_MULB: r_b   <= prod[mkwd_pkg::KS_SHIFT +: mkwd_pkg::B_W];
                mkwd_pkg::PH_T:    r_t   <= r_key - prod[mkwd_pkg::WORD_W-1:0];
                mkwd_pkg::PH_C:    r_c   <= prod[mkwd_pkg::WORD_W-1:0];
                mkwd_pkg::PH_R:    r_key <= prod[mkwd_pkg::WORD_W-1:0] - r_c;
                mkwd_pkg::PH_FIX: begin
                    r_key <= key_fixed;
                    r_ks  <= {r_ks[mkwd_pkg::WORD_W-9:0], key_fixed[7:0]};
                end
                default: r_key <= r_key;
            endcase
        end
    end

    assign o_ks = r_ks;

endmodule

[rtl/minstd_keystream_word_decrypt.sv]
// Keystream word decryptor top level: config registers, word counter,
// sequencer and output register. Uses mkwd_pkg and mkwd_gen.
// A word inside the buffer runs 4 generator steps of 5 sub-steps each on the
// one shared multiplier, then its result is loaded into the output register
// from ST_DONE; a word beyond the buffer goes from ST_IDLE straight to ST_DONE.
// A new word is taken only once the last has left ST_DONE, which waits while a result stalls.
// Reset (synchronous, i_rst_n low): state, config registers, word counter and output valid cleared.
module minstd_keystream_word_decrypt (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [mkwd_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [mkwd_pkg::WORD_W-1:0]       i_cfg_wr_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [mkwd_pkg::WORD_W-1:0]       i_data_word,
    input  logic                              i_first_word,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [mkwd_pkg::WORD_W-1:0]       o_plain_word,
    output logic [mkwd_pkg::VB_W-1:0]         o_valid_bytes,
    output logic                              o_last_word
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    t_state                         r_state;
    mkwd_pkg::t_phase               r_phase;
    logic [1:0]                     r_step;
    logic [mkwd_pkg::WORD_W-1:0]    r_offset;
    logic [mkwd_pkg::WORD_W-1:0]    r_length;
    logic [mkwd_pkg::CNT_W-1:0]     r_word_cnt;
    logic [mkwd_pkg::WORD_W-1:0]    r_data;
    logic [mkwd_pkg::VB_W-1:0]      r_vbytes;
    logic                           r_last;
    logic                           r_out_valid;
    logic [mkwd_pkg::WORD_W-1:0]    r_out_plain;
    logic [mkwd_pkg::VB_W-1:0]      r_out_vbytes;
    logic                           r_out_last;

    logic                           in_xfer;
    logic                           out_free;
    logic [mkwd_pkg::CNT_W-1:0]     n_word;
    logic [mkwd_pkg::WORD_W:0]      start_ext;
    logic [mkwd_pkg::WORD_W:0]      len_ext;
    logic [mkwd_pkg::WORD_W:0]      rem;
    logic [mkwd_pkg::WORD_W+1:0]    end_ext;
    logic [mkwd_pkg::VB_W-1:0]      n_vbytes;
    logic                           n_last;
    logic [mkwd_pkg::WORD_W-1:0]    seed;
    logic [mkwd_pkg::WORD_W-1:0]    ks;
    logic [mkwd_pkg::WORD_W-1:0]    mask;
    mkwd_pkg::t_gen_ctrl            gen_ctrl;

    assign o_ready  = (r_state == ST_IDLE);
    assign in_xfer  = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    // word position and byte count for the incoming item
    assign n_word    = i_first_word ? '0 : r_word_cnt;
    assign start_ext = {1'b0, n_word, 2'b00};
    assign len_ext   = {1'b0, r_length};
    assign rem       = len_ext - start_ext;
    assign end_ext   = {2'b00, n_word, 2'b00} + (mkwd_pkg::WORD_W+2)'(4);
    assign n_last    = end_ext >= {1'b0, len_ext};
    assign seed      = (r_length ^ r_offset) + {{(mkwd_pkg::WORD_W-mkwd_pkg::CNT_W){1'b0}}, n_word};

    always_comb begin
        if (start_ext >= len_ext) begin
            n_vbytes = '0;
        end else if (rem[mkwd_pkg::WORD_W:2] != '0) begin
            n_vbytes = 3'd4;
        end else begin
            n_vbytes = rem[mkwd_pkg::VB_W-1:0];
        end
    end

    always_comb begin
        case (r_vbytes)
            3'd0:    mask = 32'h0000_0000;
            3'd1:    mask = 32'h0000_00FF;
            3'd2:    mask = 32'h0000_FFFF;
            3'd3:    mask = 32'h00FF_FFFF;
            default: mask = 32'hFFFF_FFFF;
        endcase
    end

    assign gen_ctrl.load  = in_xfer;
    assign gen_ctrl.run   = (r_state == ST_RUN);
    assign gen_ctrl.phase = r_phase;

    mkwd_gen u_gen (
        .i_clk  (i_clk),
        .i_ctrl (gen_ctrl),
        .i_seed (seed),
        .o_ks   (ks)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= mkwd_pkg::PH_MULB;
            r_step      <= '0;
            r_offset    <= '0;
            r_length    <= '0;
            r_word_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_addr)
                    mkwd_pkg::REG_BUFFER_OFFSET: r_offset <= i_cfg_wr_data;
                    mkwd_pkg::REG_BUFFER_LENGTH: r_length <= i_cfg_wr_data;
                    default: ;
                endcase
            end

            // a new result loaded in ST_DONE takes the place of the one leaving
            if (r_out_valid && i_ready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_data     <= i_data_word;
                        r_vbytes   <= n_vbytes;
                        r_last     <= n_last;
                        r_word_cnt <= n_word + 1'b1;
                        r_phase    <= mkwd_pkg::PH_MULB;
                        r_step     <= '0;
                        // nothing to generate for a word beyond the buffer
                        r_state    <= (n_vbytes == '0) ? ST_DONE : ST_RUN;
                    end
                end
                ST_RUN: begin
                    unique case (r_phase)
                        mkwd_pkg::PH_MULB: r_phase <= mkwd_pkg::PH_T;
                        mkwd_pkg::PH_T:    r_phase <= mkwd_pkg::PH_C;
                        mkwd_pkg::PH_C:    r_phase <= mkwd_pkg::PH_R;
                        mkwd_pkg::PH_R:    r_phase <= mkwd_pkg::PH_FIX;
                        default: begin
                            r_phase <= mkwd_pkg::PH_MULB;
                            r_step  <= r_step + 1'b1;
                            if (r_step == 2'd3) begin
                                r_state <= ST_DONE;
                            end
                        end
                    endcase
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_plain  <= r_data ^ (ks & mask);
                        r_out_vbytes <= r_vbytes;
                        r_out_last   <= r_last;
                        r_state      <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_plain_word  = r_out_plain;
    assign o_valid_bytes = r_out_vbytes;
    assign o_last_word   = r_out_last;

endmodule

[rtl/mkwd_chk.sv]
// Port-level checks for minstd_keystream_word_decrypt, bound to the top level.
// Depends on mkwd_pkg for widths only.
module mkwd_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_ready,
    input logic                           o_valid,
    input logic                           i_ready,
    input logic [mkwd_pkg::WORD_W-1:0]    o_plain_word,
    input logic [mkwd_pkg::VB_W-1:0]      o_valid_bytes,
    input logic                           o_last_word
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_plain_word)
                                && $stable(o_valid_bytes) && $stable(o_last_word))
        else $error("result changed while stalled");

    a_vbytes_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_valid_bytes <= 3'd4)
        else $error("valid_bytes above four");

    // a short word must be the last one of the buffer
    a_short_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_valid_bytes != 3'd4 |-> o_last_word)
        else $error("partial word not flagged last");

    // one word at a time: busy straight after an input transfer
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready after input transfer");

endmodule

bind minstd_keystream_word_decrypt mkwd_chk u_mkwd_chk (.*);
